[rtl/core/oscillator_drift_channel_offset_assert.svh]
// ----------------------------------------------------------------------------
// oscillator drift channel offset assertion macros
// shared concurrent assertion forms used by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef OSCILLATOR_DRIFT_CHANNEL_OFFSET_ASSERT_SVH
`define OSCILLATOR_DRIFT_CHANNEL_OFFSET_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ODCO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ODCO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/odco_pkg.sv]
// ----------------------------------------------------------------------------
// odco_pkg
// shared types and constants of the oscillator drift channel offset block
// ----------------------------------------------------------------------------
package odco_pkg;

	// fixed field widths
	localparam int MEAS_W      = 26;
	localparam int OFS_W       = 27;
	localparam int CHAN_W      = 16;
	localparam int RF_W        = 30;
	localparam int LSB_W       = 24;
	localparam int CFG_AW      = 4;
	localparam int CFG_DW      = 32;
	// x256 for the q8 step and x2 for half rounding
	localparam int CHAN_SHIFT  = 9;

	localparam logic [LSB_W-1:0]  LSB_RESET = 24'd256;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = 16'h7FFF;
	localparam logic [CHAN_W-1:0] CHAN_MIN  = 16'h8000;

	// item kinds
	localparam logic KIND_MEAS    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// register indexes
	localparam logic [1:0] REG_TRACK = 2'd0;
	localparam logic [1:0] REG_RF    = 2'd1;
	localparam logic [1:0] REG_LSB   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_END,
		ST_MAG,
		ST_MUL_NX,
		ST_MUL_DL,
		ST_MUL_MR,
		ST_DIVF_LD,
		ST_DIVF_RUN,
		ST_DIVC_LD,
		ST_DIVC_RUN,
		ST_DONE
	} odco_state_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MUL_NX,
		MUL_DL,
		MUL_MR
	} odco_mul_t;

	// divider operand selection
	typedef enum logic {
		DIV_FREQ,
		DIV_CHAN
	} odco_div_t;

	typedef struct packed {
		logic             track;
		logic [RF_W-1:0]  rf;
		logic [LSB_W-1:0] lsb;
	} odco_cfg_t;

	typedef struct packed {
		logic      restart;
		logic      meas;
		logic      rd_en;
		logic      acc;
		logic      mag;
		logic      mul_en;
		odco_mul_t mul_op;
		logic      div_start;
		odco_div_t div_sel;
		logic      cap_freq;
		logic      cap_chan;
		logic      load_out;
	} odco_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
		logic track;
	} odco_sts_t;

endpackage

[rtl/core/odco_ram.sv]
// ----------------------------------------------------------------------------
// odco_ram
// generic single write port ram with a registered read port
// ----------------------------------------------------------------------------
module odco_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/odco_regs.sv]
// ----------------------------------------------------------------------------
// odco_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module odco_regs
	import odco_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output odco_cfg_t         cfg
);

	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.track <= 1'b0;
			cfg.rf    <= '0;
			cfg.lsb   <= LSB_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_TRACK: cfg.track <= pwdata[0];
				REG_RF:    cfg.rf    <= pwdata[RF_W-1:0];
				REG_LSB:   cfg.lsb   <= pwdata[LSB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_TRACK: prdata = CFG_DW'(cfg.track);
			REG_RF:    prdata = CFG_DW'(cfg.rf);
			REG_LSB:   prdata = CFG_DW'(cfg.lsb);
			default:   prdata = '0;
		endcase
	end

endmodule

[rtl/core/odco_ctrl.sv]
// ----------------------------------------------------------------------------
// odco_ctrl
// sequencer: history sweep, multiplies, divides and result hand-off
// ----------------------------------------------------------------------------
`include "oscillator_drift_channel_offset_assert.svh"

module odco_ctrl
	import odco_pkg::*;
#(
	parameter int AVG_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             kind,
	input  odco_sts_t                        sts,
	input  logic [$clog2(AVG_DEPTH+1)-1:0]   cnt,
	output logic [$clog2(AVG_DEPTH)-1:0]     rd_addr,
	output odco_cmd_t                        cmd
);

	localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
	localparam int SLOT_W = $clog2(AVG_DEPTH);

	odco_state_t      state_q;
	odco_state_t      state_d;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic             accept;
	logic             rd_last;

	// input is taken only between items
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign rd_last  = (rd_idx_q == cnt - CNT_W'(1));
	assign rd_addr  = rd_idx_q[SLOT_W-1:0];

	// state and sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SUM);
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == ST_SUM) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_RESTART) ? ST_DONE : ST_SUM;
				end
			end
			ST_SUM: begin
				if (rd_last) begin
					state_d = ST_SUM_END;
				end
			end
			ST_SUM_END:  state_d = ST_MAG;
			ST_MAG:      state_d = ST_MUL_NX;
			ST_MUL_NX:   state_d = ST_MUL_DL;
			ST_MUL_DL:   state_d = ST_MUL_MR;
			ST_MUL_MR:   state_d = ST_DIVF_LD;
			ST_DIVF_LD:  state_d = ST_DIVF_RUN;
			ST_DIVF_RUN: begin
				if (!sts.div_busy) begin
					state_d = sts.track ? ST_DIVC_LD : ST_DONE;
				end
			end
			ST_DIVC_LD:  state_d = ST_DIVC_RUN;
			ST_DIVC_RUN: begin
				if (!sts.div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd         = '0;
		cmd.mul_op  = MUL_NX;
		cmd.div_sel = DIV_FREQ;
		cmd.acc     = rd_vld_s1;
		unique case (state_q)
			ST_IDLE: begin
				cmd.restart = accept && (kind == KIND_RESTART);
				cmd.meas    = accept && (kind == KIND_MEAS);
			end
			ST_SUM:     cmd.rd_en = 1'b1;
			ST_MAG:     cmd.mag   = 1'b1;
			ST_MUL_NX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_NX;
			end
			ST_MUL_DL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_DL;
			end
			ST_MUL_MR: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MR;
			end
			ST_DIVF_LD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_FREQ;
			end
			ST_DIVF_RUN: cmd.cap_freq = !sts.div_busy;
			ST_DIVC_LD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CHAN;
			end
			ST_DIVC_RUN: cmd.cap_chan = !sts.div_busy;
			ST_DONE:     cmd.load_out = sts.out_free;
			default: begin
			end
		endcase
	end

	// a measurement always starts the history sweep
	`ODCO_ASSERT_NEXT(a_meas_to_sum, clk, arst_n, cmd.meas, state_q == ST_SUM, "measurement did not start the sweep")
	// the sweep never reads beyond the filled entries
	`ODCO_ASSERT_NOW(a_rd_in_range, clk, arst_n, state_q == ST_SUM, rd_idx_q < cnt, "history read beyond entry count")

endmodule

[rtl/core/odco_dp.sv]
// ----------------------------------------------------------------------------
// odco_dp
// datapath: reference, history ram, sum, shared multiplier, serial divider
// ----------------------------------------------------------------------------
`include "oscillator_drift_channel_offset_assert.svh"

module odco_dp
	import odco_pkg::*;
#(
	parameter int AVG_DEPTH = 8,
	parameter int XOSC_HZ   = 16000000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  odco_cmd_t                      cmd,
	input  odco_cfg_t                      cfg,
	input  logic [MEAS_W-1:0]              meas,
	input  logic [$clog2(AVG_DEPTH)-1:0]   rd_addr,
	output odco_sts_t                      sts,
	output logic [$clog2(AVG_DEPTH+1)-1:0] cnt,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [CHAN_W-1:0]              out_chan,
	output logic [OFS_W-1:0]               out_freq,
	output logic                           out_isref
);

	localparam int SLOT_W = $clog2(AVG_DEPTH);
	localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
	localparam int MAG_W  = MEAS_W + SLOT_W;
	localparam int SUM_W  = MAG_W + 1;
	localparam int A_W    = MAG_W + 1;
	localparam int PROD_W = A_W + RF_W;
	localparam int D_W    = A_W + LSB_W;
	localparam int DEN_W  = D_W + 1;
	localparam int NUM_W  = MAG_W + RF_W + CHAN_SHIFT + 1;
	localparam int DIV_CW = $clog2(NUM_W + 1);

	// item state
	logic [MEAS_W-1:0] ref_q;
	logic              have_ref_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] slot_q;

	// history ram
	logic [OFS_W-1:0]  hist_wdata;
	logic [OFS_W-1:0]  hist_rdata;

	// arithmetic
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        sum_abs;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic [A_W-1:0]          mul_a;
	logic [RF_W-1:0]         mul_b;
	logic [LSB_W-1:0]        lsb_eff;
	logic [PROD_W-1:0]       prod_q;
	logic [D_W-1:0]          d_q;

	// divider
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              q_bit;
	logic [NUM_W-1:0]  num_ld;
	logic [DEN_W-1:0]  den_ld;

	// result
	logic [CHAN_W-1:0] chan_q;
	logic [OFS_W-1:0]  freq_q;
	logic              isref_q;
	logic              q_ge_min;
	logic              q_ge_max;
	logic [CHAN_W-1:0] chan_val;

	logic [CHAN_W-1:0] out_chan_q;
	logic [OFS_W-1:0]  out_freq_q;
	logic              out_isref_q;
	logic              out_valid_q;

	assign cnt          = cnt_q;
	assign sts.div_busy = (div_cnt_q != '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.track    = cfg.track;
	assign out_valid    = out_valid_q;
	assign out_chan     = out_chan_q;
	assign out_freq     = out_freq_q;
	assign out_isref    = out_isref_q;

	// offset written for this measurement, zero for the reference itself
	assign hist_wdata = have_ref_q ? ({1'b0, meas} - {1'b0, ref_q}) : '0;

	odco_ram #(
		.WIDTH (OFS_W),
		.DEPTH (AVG_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.meas),
		.waddr (slot_q),
		.wdata (hist_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (hist_rdata)
	);

	// reference, fill count and write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_ref_q <= 1'b0;
			cnt_q      <= '0;
			slot_q     <= '0;
		end else if (cmd.restart) begin
			have_ref_q <= 1'b0;
			cnt_q      <= '0;
			slot_q     <= '0;
		end else if (cmd.meas) begin
			have_ref_q <= 1'b1;
			slot_q     <= (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
			if (cnt_q != CNT_W'(AVG_DEPTH)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.meas && !have_ref_q) begin
			ref_q <= meas;
		end
	end

	// history sum and magnitude
	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_ff @(posedge clk) begin
		if (cmd.meas) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + {{(SUM_W-OFS_W){hist_rdata[OFS_W-1]}}, hist_rdata};
		end
		if (cmd.mag) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_abs[MAG_W-1:0];
		end
	end

	// shared multiplier: n*xosc, then that times the step, then magnitude times rf
	assign lsb_eff = (cfg.lsb == '0) ? LSB_W'(1) : cfg.lsb;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_NX: begin
				mul_a = A_W'(cnt_q);
				mul_b = RF_W'(XOSC_HZ);
			end
			MUL_DL: begin
				mul_a = prod_q[A_W-1:0];
				mul_b = RF_W'(lsb_eff);
			end
			MUL_MR: begin
				mul_a = A_W'(mag_q);
				mul_b = cfg.rf;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			if (cmd.mul_op == MUL_MR) begin
				d_q <= prod_q[D_W-1:0];
			end
		end
	end

	// divider operands: round(mag/n) and round(mag*rf*256/d), both half up
	always_comb begin
		unique case (cmd.div_sel)
			DIV_FREQ: begin
				num_ld = NUM_W'({mag_q, 1'b0}) + NUM_W'(cnt_q);
				den_ld = DEN_W'({cnt_q, 1'b0});
			end
			DIV_CHAN: begin
				num_ld = NUM_W'({prod_q[MAG_W+RF_W-1:0], {CHAN_SHIFT{1'b0}}}) + NUM_W'(d_q);
				den_ld = {d_q, 1'b0};
			end
			default: begin
				num_ld = '0;
				den_ld = '0;
			end
		endcase
	end

	// restoring divider, one quotient bit per cycle, quotient shifts into num_q
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign q_bit = !diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DIV_CW'(NUM_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= num_ld;
			den_q <= den_ld;
			rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// channel saturation: magnitude limit 32768 below, 32767 above
	assign q_ge_min = |num_q[NUM_W-1:CHAN_W-1];
	assign q_ge_max = q_ge_min || (&num_q[CHAN_W-2:0]);

	always_comb begin
		if (neg_q) begin
			chan_val = q_ge_min ? CHAN_MIN : -{1'b0, num_q[CHAN_W-2:0]};
		end else begin
			chan_val = q_ge_max ? CHAN_MAX : {1'b0, num_q[CHAN_W-2:0]};
		end
	end

	// result fields of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.restart || cmd.meas) begin
			chan_q  <= '0;
			freq_q  <= '0;
			isref_q <= cmd.meas && !have_ref_q;
		end else begin
			if (cmd.cap_freq) begin
				freq_q <= neg_q ? -num_q[OFS_W-1:0] : num_q[OFS_W-1:0];
			end
			if (cmd.cap_chan) begin
				chan_q <= chan_val;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_chan_q  <= chan_q;
			out_freq_q  <= freq_q;
			out_isref_q <= isref_q;
		end
	end

	// a reference exists exactly when the history holds an entry
	`ODCO_ASSERT_NOW(a_ref_cnt, clk, arst_n, 1'b1, have_ref_q == (cnt_q != '0), "reference flag and fill count disagree")
	// restart empties the tracker
	`ODCO_ASSERT_NEXT(a_restart_clr, clk, arst_n, cmd.restart, !have_ref_q && cnt_q == '0, "restart left state behind")
	// averaged offset always fits the result field
	`ODCO_ASSERT_NOW(a_freq_fits, clk, arst_n, cmd.cap_freq, num_q[NUM_W-1:OFS_W-1] == '0, "averaged offset overflow")

endmodule

[rtl/core/oscillator_drift_channel_offset.sv]
// a restart item goes straight to the done state; its result is loaded into the output register
// once that register is free. a measurement sweeps the filled history entries into the sum,
// takes the magnitude, runs the multiplies and the frequency divide and, when tracking is
// enabled, also the channel divide, both in the bit-serial divider; NUM_W = 66 + log2(AVG_DEPTH)
// one item in work at a time; the next item is taken while a result waits in the output register
// reset clears reference, fill count, write slot and control state; history ram is not cleared
// ----------------------------------------------------------------------------
// oscillator_drift_channel_offset
// oscillator drift tracker with moving average and radio channel offset
// ----------------------------------------------------------------------------
module oscillator_drift_channel_offset
	import odco_pkg::*;
#(
	parameter int AVG_DEPTH = 8,
	parameter int XOSC_HZ   = 16000000
) (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,  // [25:0] measured_hz, rest zero
	input  logic              s_tuser,  // [0] kind
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,  // [15:0] channel_offset, [42:16] frequency_offset_hz
	output logic              m_tuser,  // [0] is_reference
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	odco_cfg_t                      cfg;
	odco_cmd_t                      cmd;
	odco_sts_t                      sts;
	logic [$clog2(AVG_DEPTH+1)-1:0] cnt;
	logic [$clog2(AVG_DEPTH)-1:0]   rd_addr;
	logic [CHAN_W-1:0]              out_chan;
	logic [OFS_W-1:0]               out_freq;

	odco_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	odco_ctrl #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.sts      (sts),
		.cnt      (cnt),
		.rd_addr  (rd_addr),
		.cmd      (cmd)
	);

	odco_dp #(
		.AVG_DEPTH (AVG_DEPTH),
		.XOSC_HZ   (XOSC_HZ)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.meas      (s_tdata[MEAS_W-1:0]),
		.rd_addr   (rd_addr),
		.sts       (sts),
		.cnt       (cnt),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_chan  (out_chan),
		.out_freq  (out_freq),
		.out_isref (m_tuser)
	);

	// pack the result fields
	assign m_tdata = {5'b0, out_freq, out_chan};

endmodule
